### design/sbfd_pkg.sv
// Shared types and constants for the sync byte frame deframer.
package sbfd_pkg;

  // Sync byte value after reset.
  localparam logic [7:0] SYNC_RESET = 8'hAA;

  // Body layout of a nominal frame: header, board id, command, then payload.
  localparam int NOMINAL_BODY  = 10;
  localparam int HEADER_IDX    = 0;
  localparam int BOARD_IDX     = 1;
  localparam int COMMAND_IDX   = 2;
  localparam int PAYLOAD_IDX   = 3;
  localparam int PAYLOAD_BYTES = 7;

  // Checksum status codes.
  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_MISMATCH = 1'b1;

  typedef logic [7:0]                 byte_t;
  typedef logic [8*PAYLOAD_BYTES-1:0] payload_t;

  // One registered input beat handed to the frame assembler.
  typedef struct packed {
    logic  valid;
    byte_t data;
  } beat_t;

  // One decoded frame.
  typedef struct packed {
    byte_t    header_byte;
    byte_t    board_id;
    byte_t    command;
    payload_t payload;
    logic     status;
  } frame_t;

endpackage

### design/sbfd_if.sv
// Channel interfaces for the received bytes, decoded frames and configuration.

interface sbfd_in_if
  import sbfd_pkg::*;
();
  logic  valid;
  logic  ready;
  byte_t rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sbfd_out_if
  import sbfd_pkg::*;
();
  logic     valid;
  logic     ready;
  byte_t    header_byte;
  byte_t    board_id;
  byte_t    command;
  payload_t payload;
  logic     status;

  modport source (output valid, output header_byte, output board_id, output command,
                  output payload, output status, input ready);
  modport sink   (input valid, input header_byte, input board_id, input command,
                  input payload, input status, output ready);
endinterface

interface sbfd_cfg_if
  import sbfd_pkg::*;
();
  logic  valid;
  logic  ready;
  byte_t sync_byte;

  modport source (output valid, output sync_byte, input ready);
  modport sink   (input valid, input sync_byte, output ready);
endinterface

### design/sync_byte_frame_deframer.sv
// Top level of the sync byte frame deframer.
//
// Takes one received byte per beat and can accept a byte every clock cycle;
// each byte passes an input register and the frame logic and, on the
// checksum byte, the result register, so a frame is valid on the output once its
// checksum byte is in the result register. Bytes are discarded until one equals the sync
// register (reset 0xAA); the next byte is a length byte and is ignored, then
// BODY_BYTES body bytes are stored and summed modulo 256, and the byte after
// them is compared with that sum. Each frame yields one result with header,
// board id, command and seven payload bytes (first payload byte in bits 7..0)
// and a status of 0 on checksum match or 1 on mismatch. Input is stalled only
// when a checksum byte meets a full result register that the sink is not taking.
// The sync register should be written only while no frame is in flight.
module sync_byte_frame_deframer
  import sbfd_pkg::*;
#(
  parameter int BODY_BYTES = 10
) (
  input  logic              clk,
  input  logic              rst_n,
  sbfd_in_if.sink           in_bus,
  sbfd_out_if.source        out_bus,
  sbfd_cfg_if.sink          cfg_bus
);

  byte_t  sync_r;
  beat_t  beat;
  logic   take;
  frame_t frame;

  // Sync byte register; writes are always taken.
  assign cfg_bus.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_r <= SYNC_RESET;
    end else if (cfg_bus.valid) begin
      sync_r <= cfg_bus.sync_byte;
    end
  end

  sbfd_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_bus.valid),
    .in_data  (in_bus.rx_byte),
    .in_ready (in_bus.ready),
    .take     (take),
    .beat     (beat)
  );

  sbfd_assembler #(
    .BODY_BYTES (BODY_BYTES)
  ) u_assembler (
    .clk       (clk),
    .rst_n     (rst_n),
    .beat      (beat),
    .sync_byte (sync_r),
    .take      (take),
    .out_valid (out_bus.valid),
    .out_ready (out_bus.ready),
    .frame     (frame)
  );

  // Result channel fields.
  assign out_bus.header_byte = frame.header_byte;
  assign out_bus.board_id    = frame.board_id;
  assign out_bus.command     = frame.command;
  assign out_bus.payload     = frame.payload;
  assign out_bus.status      = frame.status;

endmodule

### design/sbfd_in_stage.sv
// Input register stage: captures one received byte per beat.
module sbfd_in_stage
  import sbfd_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  input  byte_t in_data,
  output logic  in_ready,
  input  logic  take,
  output beat_t beat
);

  logic  valid_r;
  byte_t data_r;

  // The register can load when empty or when its beat moves on this cycle.
  assign in_ready = !valid_r || take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= in_data;
    end
  end

  assign beat.valid = valid_r;
  assign beat.data  = data_r;

endmodule

### design/sbfd_assembler.sv
// Frame assembler: sync hunt, body capture, checksum and result register.
module sbfd_assembler
  import sbfd_pkg::*;
#(
  parameter int BODY_BYTES = 10
) (
  input  logic   clk,
  input  logic   rst_n,
  input  beat_t  beat,
  input  byte_t  sync_byte,
  output logic   take,
  output logic   out_valid,
  input  logic   out_ready,
  output frame_t frame
);

  localparam int POS_W  = $clog2(BODY_BYTES + 3);
  localparam int IDX_W  = $clog2(BODY_BYTES);
  localparam logic [POS_W-1:0] POS_HUNT  = POS_W'(0);
  localparam logic [POS_W-1:0] POS_LEN   = POS_W'(1);
  localparam logic [POS_W-1:0] POS_BODY0 = POS_W'(2);
  localparam logic [POS_W-1:0] POS_CK    = POS_W'(BODY_BYTES + 2);

  logic [POS_W-1:0] pos_r, pos_nxt;
  byte_t            sum_r, sum_nxt;
  byte_t            store_r [BODY_BYTES];
  byte_t            body    [NOMINAL_BODY];
  logic             out_valid_r;
  frame_t           frame_r;
  logic             is_ck, in_body, fire, emit;
  logic [POS_W-1:0] body_off;
  logic [IDX_W-1:0] widx;
  payload_t         pay;

  // Only the checksum beat needs room in the result register.
  assign is_ck   = (pos_r == POS_CK);
  assign in_body = (pos_r >= POS_BODY0) && !is_ck;
  assign take    = !is_ck || !out_valid_r || out_ready;
  assign fire    = beat.valid && take;
  assign emit    = fire && is_ck;

  assign body_off = pos_r - POS_BODY0;
  assign widx     = body_off[IDX_W-1:0];

  // Next frame position and running sum.
  always_comb begin
    pos_nxt = pos_r;
    sum_nxt = sum_r;
    if (fire) begin
      if (pos_r == POS_HUNT) begin
        if (beat.data == sync_byte) begin
          pos_nxt = POS_LEN;
          sum_nxt = '0;
        end
      end else if (pos_r == POS_LEN) begin
        pos_nxt = POS_BODY0;
      end else if (!is_ck) begin
        pos_nxt = pos_r + POS_W'(1);
        sum_nxt = sum_r + beat.data;
      end else begin
        pos_nxt = POS_HUNT;
        sum_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= POS_HUNT;
      sum_r <= '0;
    end else begin
      pos_r <= pos_nxt;
      sum_r <= sum_nxt;
    end
  end

  // Body bytes land in their own slot; each slot is read at a fixed place.
  for (genvar i = 0; i < BODY_BYTES; i++) begin : g_store
    always_ff @(posedge clk) begin
      if (fire && in_body && (widx == IDX_W'(i))) begin
        store_r[i] <= beat.data;
      end
    end
  end

  // Nominal body view; bytes beyond a short body read as zero.
  for (genvar i = 0; i < NOMINAL_BODY; i++) begin : g_body
    if (i < BODY_BYTES) begin : g_have
      assign body[i] = store_r[i];
    end else begin : g_none
      assign body[i] = '0;
    end
  end

  for (genvar k = 0; k < PAYLOAD_BYTES; k++) begin : g_pay
    assign pay[8*k +: 8] = body[PAYLOAD_IDX + k];
  end

  // Result register: loads on the checksum beat, drains on the output handshake.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      frame_r.header_byte <= body[HEADER_IDX];
      frame_r.board_id    <= body[BOARD_IDX];
      frame_r.command     <= body[COMMAND_IDX];
      frame_r.payload     <= pay;
      frame_r.status      <= (sum_r == beat.data) ? STATUS_OK : STATUS_MISMATCH;
    end
  end

  assign out_valid = out_valid_r;
  assign frame     = frame_r;

  // The position never runs past the checksum slot.
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_CK)
    else $error("frame position out of range");

  // A checksum beat always returns the block to hunting.
  a_ck_to_hunt: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> (pos_r == POS_HUNT) && (sum_r == '0))
    else $error("no return to hunt after checksum");

  // A result appears only after a checksum beat.
  a_out_from_ck: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(emit))
    else $error("result without checksum beat");

  // A non-sync byte while hunting keeps the block hunting.
  a_hunt_stays: assert property (@(posedge clk) disable iff (!rst_n)
    fire && (pos_r == POS_HUNT) && (beat.data != sync_byte) |=> pos_r == POS_HUNT)
    else $error("left hunt without sync byte");

endmodule

### sim/sync_byte_frame_deframer_tb.sv
// Self-checking testbench for the sync byte frame deframer: directed frames, then random traffic.
`timescale 1ns / 1ps

module sync_byte_frame_deframer_tb;
  import sbfd_pkg::*;

  localparam int BODY_LEN      = 10;
  localparam int RESET_CYCLES  = 8;
  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_CYCLES   = 8;
  localparam int QUIET_LIMIT   = 500;
  localparam int RANDOM_BYTES  = 700;
  localparam int PHASES        = 6;
  localparam int MAX_REPORTS   = 10;

  // A directed row is one received byte; checksum rows carry the status they must produce.
  typedef enum logic {ROW_BYTE, ROW_CHECKSUM} row_kind_t;

  typedef struct packed {
    row_kind_t kind;
    byte_t     value;
    logic      status;
  } dir_row_t;

  localparam int DIR_ROWS = 29;
  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    // Noise while hunting is dropped.
    '{ROW_BYTE,     8'h00, STATUS_OK},
    '{ROW_BYTE,     8'h55, STATUS_OK},
    // All-ones frame at the reset sync value; ten 0xFF bytes sum to 0xF6.
    '{ROW_BYTE,     8'hAA, STATUS_OK},
    '{ROW_BYTE,     8'hFF, STATUS_OK},
    '{ROW_BYTE,     8'hFF, STATUS_OK},
    '{ROW_BYTE,     8'hFF, STATUS_OK},
    '{ROW_BYTE,     8'hFF, STATUS_OK},
    '{ROW_BYTE,     8'hFF, STATUS_OK},
    '{ROW_BYTE,     8'hFF, STATUS_OK},
    '{ROW_BYTE,     8'hFF, STATUS_OK},
    '{ROW_BYTE,     8'hFF, STATUS_OK},
    '{ROW_BYTE,     8'hFF, STATUS_OK},
    '{ROW_BYTE,     8'hFF, STATUS_OK},
    '{ROW_BYTE,     8'hFF, STATUS_OK},
    '{ROW_CHECKSUM, 8'hF6, STATUS_OK},
    // Noise, then a frame with the sync value as body data and a wrong checksum.
    '{ROW_BYTE,     8'hFF, STATUS_OK},
    '{ROW_BYTE,     8'hAA, STATUS_OK},
    '{ROW_BYTE,     8'h00, STATUS_OK},
    '{ROW_BYTE,     8'h00, STATUS_OK},
    '{ROW_BYTE,     8'hAA, STATUS_OK},
    '{ROW_BYTE,     8'h01, STATUS_OK},
    '{ROW_BYTE,     8'h80, STATUS_OK},
    '{ROW_BYTE,     8'h7F, STATUS_OK},
    '{ROW_BYTE,     8'h00, STATUS_OK},
    '{ROW_BYTE,     8'h00, STATUS_OK},
    '{ROW_BYTE,     8'h00, STATUS_OK},
    '{ROW_BYTE,     8'h00, STATUS_OK},
    '{ROW_BYTE,     8'h00, STATUS_OK},
    '{ROW_CHECKSUM, 8'h00, STATUS_MISMATCH}
  };

  logic clk = 1'b0;
  logic rst_n;

  sbfd_in_if  in_bus ();
  sbfd_out_if out_bus ();
  sbfd_cfg_if cfg_bus ();

  sync_byte_frame_deframer #(
    .BODY_BYTES (BODY_LEN)
  ) u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus),
    .cfg_bus (cfg_bus)
  );

  // Free-running clock, 2 ns period.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Deframer prediction state, kept in step with accepted beats.
  byte_t  sync_value;
  int     frame_pos;
  byte_t  body_sum;
  byte_t  body_mem [BODY_LEN];
  frame_t pending_frames [$];
  logic   status_typed = 1'b0;
  logic   typed_status;
  int     consumed_bytes = 0;

  // Idling controls and bookkeeping.
  logic src_steady  = 1'b0;
  logic sink_steady = 1'b0;
  int   sink_hold   = 0;
  int   mismatches  = 0;
  int   quiet_cycles = 0;

  // Body bytes past the configured body length read as zero.
  function automatic byte_t body_byte(int idx);
    return (idx < BODY_LEN) ? body_mem[idx] : 8'h00;
  endfunction

  // Advance the frame tracker by one received byte and queue any completed frame.
  function automatic void track_rx_byte(byte_t b);
    frame_t f;
    int     k;
    if (frame_pos == 0) begin
      if (b == sync_value) begin
        frame_pos = 1;
        body_sum  = 8'h00;
        consumed_bytes++;
      end
    end else if (frame_pos == 1) begin
      // The length byte is skipped and stays out of the sum.
      frame_pos = 2;
      consumed_bytes++;
    end else if (frame_pos < BODY_LEN + 2) begin
      body_mem[frame_pos - 2] = b;
      body_sum  = body_sum + b;
      frame_pos = frame_pos + 1;
      consumed_bytes++;
    end else begin
      f.header_byte = body_byte(HEADER_IDX);
      f.board_id    = body_byte(BOARD_IDX);
      f.command     = body_byte(COMMAND_IDX);
      for (k = 0; k < PAYLOAD_BYTES; k++) begin
        f.payload[8*k +: 8] = body_byte(PAYLOAD_IDX + k);
      end
      f.status = (body_sum == b) ? STATUS_OK : STATUS_MISMATCH;
      if (status_typed) begin
        f.status     = typed_status;
        status_typed = 1'b0;
      end
      pending_frames = {pending_frames, f};
      frame_pos = 0;
      body_sum  = 8'h00;
      consumed_bytes++;
    end
  endfunction

  function automatic void compare_field(string field_name, logic [63:0] exp_v,
                                        logic [63:0] act_v);
    if (exp_v !== act_v) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
        $display("Mismatch on %s: expected %h, got %h", field_name, exp_v, act_v);
      end
    end
  endfunction

  // Compare one received frame with the oldest expected frame.
  function automatic void check_frame();
    frame_t exp_f;
    if (pending_frames.size() == 0) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
        $display("Unexpected frame: header %h board %h command %h status %b",
                 out_bus.header_byte, out_bus.board_id, out_bus.command, out_bus.status);
      end
      return;
    end
    exp_f = pending_frames.pop_front();
    compare_field("header_byte", 64'(exp_f.header_byte), 64'(out_bus.header_byte));
    compare_field("board_id", 64'(exp_f.board_id), 64'(out_bus.board_id));
    compare_field("command", 64'(exp_f.command), 64'(out_bus.command));
    compare_field("payload", 64'(exp_f.payload), 64'(out_bus.payload));
    compare_field("status", 64'(exp_f.status), 64'(out_bus.status));
  endfunction

  // Result sink: check each accepted beat, then stall for a random number of cycles.
  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready) begin
      check_frame();
      sink_hold = sink_steady ? 0 : $urandom_range(0, 9);
    end else if (sink_hold > 0) begin
      sink_hold = sink_hold - 1;
    end
    out_bus.ready <= (sink_hold == 0);
  end

  // Watchdog on cycles where no channel moves a beat.
  always @(posedge clk) begin
    if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Present one byte after a random gap and track it once the beat is taken.
  task automatic send_byte(input byte_t b);
    int gap;
    gap = src_steady ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid   <= 1'b1;
    in_bus.rx_byte <= b;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    track_rx_byte(b);
  endtask

  // Let all frames drain and the pipeline empty, then load a new sync value.
  task automatic write_sync_when_idle(input byte_t v);
    in_bus.valid <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_bus.valid     <= 1'b1;
    cfg_bus.sync_byte <= v;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    cfg_bus.valid <= 1'b0;
    sync_value = v;
  endtask

  // Body bytes lean toward the extremes and the current sync value.
  function automatic byte_t pick_body_byte();
    case ($urandom_range(0, 7))
      0:       return sync_value;
      1:       return 8'h00;
      2:       return 8'hFF;
      default: return byte_t'($urandom);
    endcase
  endfunction

  // Send a complete frame, optionally with a corrupted checksum.
  task automatic send_frame(input logic corrupt);
    byte_t sum;
    byte_t b;
    int    i;
    sum = 8'h00;
    send_byte(sync_value);
    send_byte(byte_t'($urandom));
    for (i = 0; i < BODY_LEN; i++) begin
      b   = pick_body_byte();
      sum = sum + b;
      send_byte(b);
    end
    if (corrupt) begin
      sum = sum ^ byte_t'($urandom_range(1, 255));
    end
    send_byte(sum);
  endtask

  // Main stimulus: reset, directed rows, then random phases at several sync values.
  initial begin
    int    row;
    int    phase;
    int    budget;
    byte_t phase_sync [PHASES];

    rst_n             = 1'b0;
    in_bus.valid      = 1'b0;
    in_bus.rx_byte    = 8'h00;
    cfg_bus.valid     = 1'b0;
    cfg_bus.sync_byte = 8'h00;
    sync_value        = SYNC_RESET;
    frame_pos         = 0;
    body_sum          = 8'h00;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows at the reset sync value.
    for (row = 0; row < DIR_ROWS; row++) begin
      if (DIRECTED[row].kind == ROW_CHECKSUM) begin
        status_typed = 1'b1;
        typed_status = DIRECTED[row].status;
      end
      send_byte(DIRECTED[row].value);
    end

    // Random phases; each starts with a sync write while the block is idle.
    phase_sync = '{8'h00, 8'hFF, byte_t'($urandom), 8'h5A, byte_t'($urandom), SYNC_RESET};
    for (phase = 0; phase < PHASES; phase++) begin
      src_steady  = (phase == 1) || (phase == 3);
      sink_steady = (phase == 1) || (phase == 4);
      write_sync_when_idle(phase_sync[phase]);
      budget = consumed_bytes + RANDOM_BYTES / PHASES;
      while (consumed_bytes < budget) begin
        case ($urandom_range(0, 9))
          0, 1:    send_byte(byte_t'($urandom));
          2:       send_frame(1'b1);
          default: send_frame(1'b0);
        endcase
      end
      // Complete any frame that noise left open so the next write sees a hunting block.
      while (frame_pos != 0) send_byte(byte_t'($urandom));
    end
    in_bus.valid <= 1'b0;

    // Drain outstanding frames, then keep watching for strays before the verdict.
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatches == 0 && pending_frames.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
